// ----- hw/rtl/tfa_pkg.sv -----
package tfa_pkg;

  localparam int CoordW = 24;
  localparam int SumW   = 25;
  localparam int EdgeW  = 26;
  localparam int VelW   = 16;
  localparam int ProdW  = 42;
  localparam int CrossW = 43;
  localparam int MagW   = 42;
  localparam int QW     = 58;
  localparam int AccW   = 63;
  localparam int IndexW = 1;
  localparam int DivCntW = 6;

  // Queue between the front end and the back end; the depth is a power of two.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [AccW-1:0] SumMax = {AccW{1'b1}};

  localparam logic [IndexW-1:0] RegUseConc = 1'b0;
  localparam logic [IndexW-1:0] RegShift   = 1'b1;

  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatZero = 2'd1;
  localparam logic [1:0] StatSat  = 2'd2;

  // Work handed from the front end to the back end.
  typedef struct packed {
    logic signed [EdgeW-1:0] ex;
    logic signed [EdgeW-1:0] ey;
    logic signed [VelW-1:0]  vx;
    logic signed [VelW-1:0]  vy;
    logic [15:0]             depth;
    logic [15:0]             conc;
    logic                    last;
  } cell_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_DIV,
    BK_OUT
  } bk_state_t;

endpackage

// ----- hw/rtl/tfa_front.sv -----
module tfa_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   start_row,
  input  logic signed [23:0]     xl,
  input  logic signed [23:0]     yl,
  input  logic signed [23:0]     xr,
  input  logic signed [23:0]     yr,
  input  logic signed [15:0]     vx,
  input  logic signed [15:0]     vy,
  input  logic [15:0]            depth,
  input  logic [15:0]            conc,
  input  logic                   last,
  output logic                   q_valid,
  input  logic                   q_ready,
  output tfa_pkg::cell_t         q_data
);
  import tfa_pkg::*;

  logic signed [SumW-1:0] px_r, py_r;
  logic signed [SumW-1:0] sx, sy;
  cell_t                  fifo_r [QDepth];
  logic [QPtrW-1:0]       wp_r, rp_r;
  logic [QPtrW:0]         cnt_r;
  logic                   push, pop;
  cell_t                  cell_d;

  assign in_ready = (cnt_r != (QPtrW+1)'(QDepth));
  assign sx = SumW'(xl) + SumW'(xr);
  assign sy = SumW'(yl) + SumW'(yr);
  assign push = in_valid && in_ready && !start_row;
  assign q_valid = (cnt_r != '0);
  assign pop = q_valid && q_ready;
  assign q_data = fifo_r[rp_r];

  always_comb begin
    cell_d.ex    = EdgeW'(sx) - EdgeW'(px_r);
    cell_d.ey    = EdgeW'(sy) - EdgeW'(py_r);
    cell_d.vx    = vx;
    cell_d.vy    = vy;
    cell_d.depth = depth;
    cell_d.conc  = conc;
    cell_d.last  = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0;
      py_r <= '0;
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (in_valid && in_ready) begin
        px_r <= sx;
        py_r <= sy;
      end
      if (push) wp_r <= wp_r + QPtrW'(1);
      if (pop) rp_r <= rp_r + QPtrW'(1);
      cnt_r <= cnt_r + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= cell_d;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPtrW+1)'(QDepth))
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == (QPtrW+1)'(QDepth)) |-> !push)
    else $error("push into full queue");
  a_start_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && start_row) |-> !push)
    else $error("start word queued");
endmodule

// ----- hw/rtl/tfa_back.sv -----
module tfa_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                use_conc,
  input  logic [5:0]          shift,
  input  logic                q_valid,
  output logic                q_ready,
  input  tfa_pkg::cell_t      q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [62:0]         disc_o,
  output logic [62:0]         res_o,
  output logic [1:0]          stat_o
);
  import tfa_pkg::*;

  bk_state_t state_r, state_nxt;

  // Stage 1: products.
  logic                       s1_v_r, s1_last_r;
  logic signed [ProdW-1:0]    p1_r, p2_r;
  logic [15:0]                s1_depth_r, s1_conc_r;
  // Stage 2: magnitude.
  logic                       s2_v_r, s2_last_r;
  logic [MagW-1:0]            mag_r;
  logic [15:0]                s2_depth_r, s2_conc_r;
  // Stage 3: cell discharge.
  logic                       s3_v_r, s3_last_r;
  logic [QW-1:0]              q_r;
  logic [15:0]                s3_conc_r;
  // Stage 4: mass term.
  logic                       s4_v_r, s4_last_r, s4_msat_r;
  logic [QW-1:0]              s4_q_r;
  logic [QW+15:0]             m_r;

  logic [AccW-1:0] dsum_r, msum_r;
  logic            sat_r;
  logic            busy;

  logic signed [CrossW-1:0] xprod;
  logic [QW+15:0]           qd;
  logic [AccW:0]            dadd, madd;
  logic [AccW-1:0]          mterm;

  // Divider.
  logic [AccW-1:0] num_r, den_r, quo_r, rem_r;
  logic [DivCntW-1:0] dcnt_r;
  logic [AccW:0]      trial;
  logic [AccW-1:0]    dis_r, rv_r;
  logic [1:0]         st_r;

  assign busy = s1_v_r || s2_v_r || s3_v_r || s4_v_r;
  assign q_ready = (state_r == BK_RUN) && !(s4_v_r && s4_last_r) &&
                   !(s3_v_r && s3_last_r) && !(s2_v_r && s2_last_r) &&
                   !(s1_v_r && s1_last_r);

  assign xprod = CrossW'(p1_r) - CrossW'(p2_r);
  assign qd = ((QW+16)'(mag_r) * (QW+16)'(s2_depth_r)) >> 1;
  assign mterm = s4_msat_r ? SumMax : AccW'(m_r);
  assign dadd = {1'b0, dsum_r} + {6'b0, s4_q_r};
  assign madd = {1'b0, msum_r} + {1'b0, mterm};
  assign trial = {rem_r, num_r[AccW-1]} - {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_RUN: if (s4_v_r && s4_last_r) state_nxt = BK_DIV;
      BK_DIV: if (dcnt_r == '0) state_nxt = BK_OUT;
      BK_OUT: if (out_ready) state_nxt = BK_RUN;
      default: state_nxt = BK_RUN;
    endcase
  end

  always_comb begin
    out_valid = (state_r == BK_OUT);
    disc_o = dis_r;
    res_o  = use_conc ? rv_r : dis_r;
    stat_o = st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_RUN;
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0; s4_v_r <= 1'b0;
      dsum_r <= '0; msum_r <= '0; sat_r <= 1'b0;
      dcnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      s1_v_r <= q_valid && q_ready;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      if (s4_v_r) begin
        logic [AccW-1:0] dn, mn;
        logic            sn;
        sn = sat_r;
        if (dadd > {1'b0, SumMax}) begin dn = SumMax; sn = 1'b1; end
        else dn = AccW'(dadd);
        mn = msum_r;
        if (use_conc) begin
          if (s4_msat_r) sn = 1'b1;
          if (madd > {1'b0, SumMax}) begin mn = SumMax; sn = 1'b1; end
          else mn = AccW'(madd);
        end
        if (s4_last_r) begin
          dis_r <= dn;
          num_r <= mn;
          den_r <= dn;
          rem_r <= '0;
          quo_r <= '0;
          dcnt_r <= DivCntW'(AccW);
          st_r <= sn ? StatSat : ((dn == '0) ? StatZero : StatOk);
          dsum_r <= '0; msum_r <= '0; sat_r <= 1'b0;
        end else begin
          dsum_r <= dn; msum_r <= mn; sat_r <= sn;
        end
      end
      if (state_r == BK_DIV && dcnt_r != '0) begin
        dcnt_r <= dcnt_r - 1'b1;
        num_r <= num_r << 1;
        if (!trial[AccW]) begin
          rem_r <= AccW'(trial);
          quo_r <= {quo_r[AccW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[AccW-2:0], num_r[AccW-1]};
          quo_r <= {quo_r[AccW-2:0], 1'b0};
        end
      end
      if (state_r == BK_DIV && dcnt_r == '0)
        rv_r <= (den_r == '0) ? '0 : quo_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r <= ProdW'(q_data.vx) * ProdW'(q_data.ey);
    p2_r <= ProdW'(q_data.vy) * ProdW'(q_data.ex);
    s1_depth_r <= q_data.depth;
    s1_conc_r <= q_data.conc;
    s1_last_r <= q_data.last;
    mag_r <= xprod[CrossW-1] ? MagW'(-xprod) : MagW'(xprod);
    s2_depth_r <= s1_depth_r;
    s2_conc_r <= s1_conc_r;
    s2_last_r <= s1_last_r;
    q_r <= QW'(qd >> shift);
    s3_conc_r <= s2_conc_r;
    s3_last_r <= s2_last_r;
    s4_q_r <= q_r;
    m_r <= (QW+16)'(q_r) * (QW+16)'(s3_conc_r);
    s4_msat_r <= ((QW+16)'(q_r) * (QW+16)'(s3_conc_r)) > (QW+16)'(SumMax);
    s4_last_r <= s3_last_r;
  end

  a_pipe_one_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_RUN) |-> !busy)
    else $error("cell in flight during divide");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(dis_r))
    else $error("result dropped");
  a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> (dsum_r == '0 && !sat_r))
    else $error("sums not cleared at end");
endmodule

// ----- hw/rtl/transect_flux_accumulator.sv -----
// Transect flux accumulator.
// in_ channel: one word per grid cell. tuser[0] marks a start word that only
// loads the first node pair; tlast marks the last cell of a transect.
// Each cell word adds |v x e| * depth / 2 >> product_shift to the discharge
// sum and, with use_concentration set, that times the concentration to the
// mass sum. Both sums saturate at 2^63-1.
// out_ channel: one word per transect, carrying the discharge, the result
// (discharge, or mass/discharge) and a status code.
// Cells are taken one per cycle while the back end runs and no last cell is in
// the four-stage product pipeline. A last cell drains that pipeline, then a
// bit-serial divider runs before the transect's result appears.
// Words keep entering the four-entry queue during that time until it fills.
// A stalled result holds out_tvalid and its data; no further cell is taken
// by the back end until the result word leaves.
// Reset clears the sums, the node pair, the queue and the registers
// (use_concentration 0, product_shift 16).
module transect_flux_accumulator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [5:0]   cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // node_x_left, node_y_left, node_x_right, node_y_right, velocity_x,
  // velocity_y, water_depth, concentration
  input  logic [159:0] in_tdata,
  input  logic [0:0]   in_tuser, // start_row
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata // discharge, result_value, status
);
  import tfa_pkg::*;

  logic       use_conc_r;
  logic [5:0] shift_r;
  logic       q_valid, q_ready;
  cell_t      q_data;
  logic [62:0] disc, res;
  logic [1:0]  stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_conc_r <= 1'b0;
      shift_r <= 6'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegUseConc: use_conc_r <= cfg_data[0];
        RegShift:   shift_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tfa_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .start_row(in_tuser[0]),
    .xl(in_tdata[23:0]), .yl(in_tdata[47:24]),
    .xr(in_tdata[71:48]), .yr(in_tdata[95:72]),
    .vx(in_tdata[111:96]), .vy(in_tdata[127:112]),
    .depth(in_tdata[143:128]), .conc(in_tdata[159:144]),
    .last(in_tlast),
    .q_valid, .q_ready, .q_data
  );

  tfa_back u_back (
    .clk, .rst_n,
    .use_conc(use_conc_r), .shift(shift_r),
    .q_valid, .q_ready, .q_data,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .disc_o(disc), .res_o(res), .stat_o(stat)
  );

  assign out_tdata = {stat, res, disc};
endmodule

// ----- tb/transect_flux_accumulator_test.sv -----
`timescale 1ns / 1ps

module transect_flux_accumulator_test;
  import tfa_pkg::*;

  localparam logic [62:0] FluxMax = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    bit                 start;
    bit                 last;
    logic signed [23:0] xl, yl, xr, yr;
    logic signed [15:0] vx, vy;
    logic [15:0]        depth, conc;
  } cell_word_t;

  typedef struct {
    logic [62:0] discharge;
    logic [62:0] value;
    logic [1:0]  status;
  } transect_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = '0;
  logic [5:0]   cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [159:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;

  transect_flux_accumulator u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cell_word_t       cell_queue[$];
  transect_result_t result_queue[$];
  cell_word_t       cur_cell;

  // Copy of the block's registers and state.
  bit          conc_mode = 1'b0;
  int unsigned q_shift = 16;
  longint      prev_sx = 0, prev_sy = 0;
  logic [63:0] flow_sum = '0, mass_sum = '0;
  bit          sat_seen = 1'b0;

  int  words_pushed = 0, words_taken = 0, results_seen = 0, mismatches = 0;
  int  in_gap = 0, out_gap = 0;
  bit  quiet = 1'b0, hold_out = 1'b0;

  function automatic logic [63:0] flux_add(logic [63:0] a, logic [63:0] b);
    if (b > {1'b0, FluxMax} - a) begin
      sat_seen = 1'b1;
      return {1'b0, FluxMax};
    end
    return a + b;
  endfunction

  function automatic void predict_cell(cell_word_t w);
    longint sx, sy, ex, ey, xprod;
    logic [63:0] q;
    logic [127:0] m;
    transect_result_t r;
    sx = longint'(w.xl) + longint'(w.xr);
    sy = longint'(w.yl) + longint'(w.yr);
    if (w.start) begin
      prev_sx = sx;
      prev_sy = sy;
      return;
    end
    ex = sx - prev_sx;
    ey = sy - prev_sy;
    prev_sx = sx;
    prev_sy = sy;
    xprod = longint'(w.vx) * ey - longint'(w.vy) * ex;
    if (xprod < 0) xprod = -xprod;
    q = (64'(xprod) * 64'(w.depth)) >> 1;
    q = q >> q_shift;
    flow_sum = flux_add(flow_sum, q);
    if (conc_mode) begin
      m = 128'(q) * 128'(w.conc);
      if (m > 128'(FluxMax)) begin
        sat_seen = 1'b1;
        m = 128'(FluxMax);
      end
      mass_sum = flux_add(mass_sum, m[63:0]);
    end
    if (!w.last) return;
    r.discharge = flow_sum[62:0];
    if (conc_mode)
      r.value = (r.discharge != 0) ? mass_sum[62:0] / r.discharge : '0;
    else
      r.value = r.discharge;
    if (sat_seen) r.status = StatSat;
    else if (r.discharge == 0) r.status = StatZero;
    else r.status = StatOk;
    result_queue.push_back(r);
    flow_sum = '0;
    mass_sum = '0;
    sat_seen = 1'b0;
  endfunction

  // Input driver: holds a word until it is taken, then pulls the next one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_cell(cur_cell);
        words_taken++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (cell_queue.size() > 0) begin
          cur_cell = cell_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {cur_cell.conc, cur_cell.depth, cur_cell.vy, cur_cell.vx,
                       cur_cell.yr, cur_cell.xr, cur_cell.yl, cur_cell.xl};
          in_tuser <= cur_cell.start;
          in_tlast <= cur_cell.last;
          if (!quiet && $urandom_range(0, 6) == 0) in_gap = $urandom_range(1, 10);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin
    transect_result_t exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (result_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", out_tdata);
        end else begin
          exp_r = result_queue.pop_front();
          if (out_tdata[62:0] !== exp_r.discharge || out_tdata[125:63] !== exp_r.value ||
              out_tdata[127:126] !== exp_r.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected q=%0d v=%0d st=%0d, got q=%0d v=%0d st=%0d",
                       results_seen, exp_r.discharge, exp_r.value, exp_r.status,
                       out_tdata[62:0], out_tdata[125:63], out_tdata[127:126]);
          end
        end
      end
      if (out_gap > 0) out_gap--;
      else if (!quiet && $urandom_range(0, 6) == 0) out_gap = $urandom_range(1, 10);
      out_tready <= !hold_out && (out_gap == 0);
    end
  end

  // One long receiver hold-off while many short transects are queued, so the
  // input queue fills and backs up.
  initial begin
    wait (words_taken >= 160);
    hold_out = 1'b1;
    repeat (400) @(posedge clk);
    hold_out = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL transect_flux_accumulator");
    $finish;
  end

  function automatic cell_word_t rand_cell(bit start, bit last);
    cell_word_t w;
    bit wide;
    wide = $urandom_range(0, 2) == 0;
    w.start = start;
    w.last = last;
    w.xl = wide ? 24'($urandom) : 24'($signed($urandom_range(0, 4000)) - 2000);
    w.yl = wide ? 24'($urandom) : 24'($signed($urandom_range(0, 4000)) - 2000);
    w.xr = wide ? 24'($urandom) : 24'($signed($urandom_range(0, 4000)) - 2000);
    w.yr = wide ? 24'($urandom) : 24'($signed($urandom_range(0, 4000)) - 2000);
    w.vx = 16'($urandom);
    w.vy = 16'($urandom);
    w.depth = 16'($urandom);
    w.conc = 16'($urandom);
    return w;
  endfunction

  function automatic cell_word_t edge_cell(bit start, bit last, logic signed [23:0] c,
                                           logic signed [15:0] v, logic [15:0] d);
    cell_word_t w;
    w.start = start;
    w.last = last;
    w.xl = c;
    w.yl = -c;
    w.xr = c;
    w.yr = ~c;
    w.vx = v;
    w.vy = -v;
    w.depth = d;
    w.conc = d;
    return w;
  endfunction

  task automatic push(cell_word_t w);
    cell_queue.push_back(w);
    words_pushed++;
  endtask

  task automatic drain;
    wait (cell_queue.size() == 0 && words_taken == words_pushed && result_queue.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [5:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegUseConc) conc_mode = value[0];
    else q_shift = 32'(value);
  endtask

  task automatic random_phase(int count);
    int target, n;
    target = words_pushed + count;
    while (words_pushed < target) begin
      case ($urandom_range(0, 9))
        0: push(rand_cell(1'b0, 1'($urandom_range(0, 1))));  // cell with no start word
        1: push(rand_cell(1'b1, 1'b1));                      // start carrying the end flag
        default: begin
          push(rand_cell(1'b1, 1'b0));
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) begin
            if (i == n / 2 && $urandom_range(0, 5) == 0) push(rand_cell(1'b1, 1'b0));
            push(rand_cell(1'b0, i == n - 1));
          end
        end
      endcase
    end
  endtask

  initial begin
    int phase_cfg[6][2] = '{'{1, 0}, '{0, 40}, '{1, 40}, '{0, 0}, '{1, 8}, '{1, 16}};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Default registers: the first cell runs from the reset node pair.
    push(edge_cell(1'b0, 1'b1, 24'sh7FFFFF, -16'sd32768, 16'hFFFF));
    push(edge_cell(1'b1, 1'b1, 24'sh000010, 16'sd5, 16'd3));     // start with end flag
    push(edge_cell(1'b0, 1'b1, 24'sh000010, 16'sd5, 16'd3));     // zero edge
    push(edge_cell(1'b1, 1'b0, -24'sh800000, 16'sh7FFF, 16'hFFFF));
    push(edge_cell(1'b0, 1'b0, 24'sh7FFFFF, 16'sh7FFF, 16'hFFFF));
    push(edge_cell(1'b1, 1'b0, 24'sh000000, 16'sh0000, 16'h0000)); // start mid transect
    push(edge_cell(1'b0, 1'b1, -24'sh800000, -16'sd32768, 16'h8000));
    drain();

    write_reg(RegUseConc, 6'd1);
    write_reg(RegShift, 6'd0);
    push(edge_cell(1'b1, 1'b0, -24'sh800000, 16'sh7FFF, 16'hFFFF));
    push(edge_cell(1'b0, 1'b1, 24'sh7FFFFF, 16'sh7FFF, 16'hFFFF));  // mass saturates
    push(edge_cell(1'b1, 1'b0, 24'sh000100, 16'sh1234, 16'hFFFF));
    push(edge_cell(1'b0, 1'b1, 24'sh000100, 16'sh1234, 16'hFFFF));  // zero discharge
    push(edge_cell(1'b1, 1'b0, 24'sh000020, 16'sh0400, 16'h0000));
    push(edge_cell(1'b0, 1'b0, 24'sh000040, 16'sh0400, 16'h0200));
    drain();
    write_reg(RegUseConc, 6'd0);  // register flipped in the middle of a transect
    push(edge_cell(1'b0, 1'b1, 24'sh000060, 16'sh0400, 16'h0300));
    drain();

    // Long transect of large cells, building a big discharge sum short of saturation.
    push(edge_cell(1'b1, 1'b0, -24'sh800000, 16'sh7FFF, 16'hFFFF));
    for (int i = 0; i < 130; i++)
      push(edge_cell(1'b0, i == 129, (i % 2) ? -24'sh800000 : 24'sh7FFFFF,
                     16'sh7FFF, 16'hFFFF));
    drain();

    foreach (phase_cfg[p]) begin
      write_reg(RegUseConc, 6'(phase_cfg[p][0]));
      write_reg(RegShift, 6'(phase_cfg[p][1]));
      if (p == 5) quiet = 1'b1;
      random_phase(p == 0 ? 60 : 50);
      drain();
    end

    $display("Checked %0d transect results from %0d words over several register settings,",
             results_seen, words_taken);
    $display("including saturation, zero discharge and a long output stall.");
    if (mismatches == 0 && result_queue.size() == 0)
      $display("PASS transect_flux_accumulator");
    else
      $display("FAIL transect_flux_accumulator");
    $finish;
  end

endmodule
